// File: rtl/core/tilt_fall_motion_classifier_core_defines.svh
// Assertion macros shared by the tilt/fall classifier RTL
`ifndef TILT_FALL_MOTION_CLASSIFIER_CORE_DEFINES_SVH
`define TILT_FALL_MOTION_CLASSIFIER_CORE_DEFINES_SVH
// Assert that an antecedent implies a consequent in the same cycle
`define TFMC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Assert that an antecedent implies a consequent in the next cycle
`define TFMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// File: rtl/core/tfmc_pkg.sv
// Package: shared types and constants of the tilt/fall classifier
`timescale 1ns / 1ps
package tfmc_pkg;
   localparam int ANGLE_FRAC_BITS = 7;
   localparam int CORDIC_STEPS    = 16;
   localparam int ATAN_LEN        = 24;
   localparam int ZW              = 26;   // Q16 degree accumulator width
   localparam int CW              = 30;   // CORDIC datapath width

   // Register indexes
   localparam logic [2:0] REG_SMOOTH  = 3'd0;
   localparam logic [2:0] REG_GYRO    = 3'd1;
   localparam logic [2:0] REG_ACCEL   = 3'd2;
   localparam logic [2:0] REG_INVERT  = 3'd3;
   localparam logic [2:0] REG_TILTMIN = 3'd4;
   localparam logic [2:0] REG_UPRIGHT = 3'd5;
   localparam logic [2:0] REG_CONFIRM = 3'd6;

   localparam logic [1:0] ORIENT_UPRIGHT  = 2'd0;
   localparam logic [1:0] ORIENT_TILTED   = 2'd1;
   localparam logic [1:0] ORIENT_INVERTED = 2'd2;
   localparam logic [1:0] MOTION_STILL    = 2'd0;
   localparam logic [1:0] MOTION_MOVING   = 2'd1;
   localparam logic [1:0] MOTION_SHOCK    = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQUARE, ST_ROOT, ST_CORDIC_P, ST_CORDIC_R,
      ST_SMOOTH_P, ST_SMOOTH_R, ST_TILT, ST_DECIDE, ST_OUT
   } state_type;

   // CORDIC start/finish handshake between top level and unit
   typedef struct packed {
      logic start;
      logic done;
   } cordic_ctl_type;

   function automatic logic [ZW-1:0] atan_q16(input logic [4:0] i);
      logic [ZW-1:0] v;
      case (i)
         5'd0: v = 26'd2949120;  5'd1: v = 26'd1740967;
         5'd2: v = 26'd919879;   5'd3: v = 26'd466945;
         5'd4: v = 26'd234379;   5'd5: v = 26'd117304;
         5'd6: v = 26'd58666;    5'd7: v = 26'd29335;
         5'd8: v = 26'd14668;    5'd9: v = 26'd7334;
         5'd10: v = 26'd3667;    5'd11: v = 26'd1833;
         5'd12: v = 26'd917;     5'd13: v = 26'd458;
         5'd14: v = 26'd229;     5'd15: v = 26'd115;
         5'd16: v = 26'd57;      5'd17: v = 26'd29;
         5'd18: v = 26'd14;      5'd19: v = 26'd7;
         5'd20: v = 26'd4;       5'd21: v = 26'd2;
         5'd22: v = 26'd1;
         default: v = '0;
      endcase
      return v;
   endfunction
endpackage

// File: rtl/core/tilt_fall_motion_classifier_core.sv
// Top level: tilt/fall motion classifier with APB register file
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | kind, accel, gyro, time_ms
//  rsp     | out       | rsp_valid/rsp_ready  | angles, orientation, motion, flags
//  csr     | in/out    | APB psel/penable     | seven registers at 4*i
// A sensor transaction steps from accept to the next accept through six square
// steps, a 24-digit square root, two CORDIC runs (early exit once y is zero), two
// shift-add smoothing passes, then the tilt square, the decision and the post.
// A clear transaction skips to the tilt square and posts.
// A result waiting in the output register lets the next transaction run; that one
// holds in its post step until the register frees. Reset is synchronous.
`timescale 1ns / 1ps
`include "tilt_fall_motion_classifier_core_defines.svh"
module tilt_fall_motion_classifier_core #(
   parameter int ANGLE_FRAC_BITS = tfmc_pkg::ANGLE_FRAC_BITS,
   parameter int CORDIC_STEPS    = tfmc_pkg::CORDIC_STEPS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_kind,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   input  logic signed [15:0] req_gyro_x,
   input  logic signed [15:0] req_gyro_y,
   input  logic signed [15:0] req_gyro_z,
   input  logic [31:0]        req_time_ms,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_pitch_angle,
   output logic signed [15:0] rsp_roll_angle,
   output logic [1:0]         rsp_orientation,
   output logic [1:0]         rsp_motion_level,
   output logic               rsp_fall_latched,
   output logic               rsp_tilt_timing,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   localparam int CW = tfmc_pkg::CW;

   // configuration registers
   logic [6:0]  pct_ff;
   logic [15:0] glim_ff, alim_ff, confirm_ff;
   logic [7:0]  inv_ff, tmin_ff, up_ff;
   logic [2:0]  ridx;
   logic        wr;
   assign pready = 1'b1;
   assign ridx   = paddr[4:2];
   assign wr     = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         pct_ff <= 7'd20; glim_ff <= 16'd655; alim_ff <= 16'd20480;
         inv_ff <= 8'd135; tmin_ff <= 8'd45; up_ff <= 8'd20; confirm_ff <= 16'd500;
      end else if (wr) begin
         case (ridx)
            tfmc_pkg::REG_SMOOTH:  pct_ff <= pwdata[6:0];
            tfmc_pkg::REG_GYRO:    glim_ff <= pwdata[15:0];
            tfmc_pkg::REG_ACCEL:   alim_ff <= pwdata[15:0];
            tfmc_pkg::REG_INVERT:  inv_ff <= pwdata[7:0];
            tfmc_pkg::REG_TILTMIN: tmin_ff <= pwdata[7:0];
            tfmc_pkg::REG_UPRIGHT: up_ff <= pwdata[7:0];
            tfmc_pkg::REG_CONFIRM: confirm_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (ridx)
         tfmc_pkg::REG_SMOOTH:  prdata = {25'd0, pct_ff};
         tfmc_pkg::REG_GYRO:    prdata = {16'd0, glim_ff};
         tfmc_pkg::REG_ACCEL:   prdata = {16'd0, alim_ff};
         tfmc_pkg::REG_INVERT:  prdata = {24'd0, inv_ff};
         tfmc_pkg::REG_TILTMIN: prdata = {24'd0, tmin_ff};
         tfmc_pkg::REG_UPRIGHT: prdata = {24'd0, up_ff};
         tfmc_pkg::REG_CONFIRM: prdata = {16'd0, confirm_ff};
         default:               prdata = '0;
      endcase
   end

   // state
   tfmc_pkg::state_type state_ff, state_in;
   logic signed [15:0] ps_ff, rs_ff, ax_ff, ay_ff, az_ff;
   logic signed [15:0] gx_ff, gy_ff, gz_ff;
   logic [31:0]        now_ff, tstart_ff;
   logic               kind_ff, tact_ff, fall_ff;
   logic [1:0]         mot_ff;
   logic [4:0]         cnt_ff;
   logic [2:0]         sq_ff;    // square term selector
   // squaring accumulators
   logic [33:0]        g2_ff, a2_ff;
   logic [31:0]        yz2_ff;
   // square root (value, remainder, root)
   logic [47:0]        rv_ff;
   logic [25:0]        rem_ff;
   logic [23:0]        root_ff;
   // pitch/roll raw angles
   logic signed [15:0] pt_ff, rt_ff;
   // smoothing: bit-serial multiply of diff by pct
   logic signed [23:0] prod_ff;
   logic [6:0]         mplr_ff;
   // tilt square
   logic [32:0]        tsq_ff;
   // output register
   logic               ov_ff;
   logic signed [15:0] o_p_ff, o_r_ff;
   logic [1:0]         o_or_ff, o_mo_ff;
   logic               o_fa_ff, o_tt_ff;

   tfmc_pkg::cordic_ctl_type cc;
   logic signed [CW-1:0]     cy, cx;
   logic signed [15:0]       cang;

   tfmc_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .start(cc.start),
      .y_init(cy), .x_init(cx), .done(cc.done), .angle(cang)
   );

   // square root step (radix-2 digit recurrence)
   logic [25:0] rcat;
   assign rcat = {rem_ff[23:0], rv_ff[47:46]};
   logic        rge;
   assign rge = rcat >= {root_ff, 2'b01};

   assign req_ready = (state_ff == tfmc_pkg::ST_IDLE);
   assign cc.start  = (state_ff == tfmc_pkg::ST_ROOT && cnt_ff == 5'd23)
                   || (state_ff == tfmc_pkg::ST_CORDIC_P && cc.done);
   // pitch starts on the last root digit, so take the root with that digit in
   always_comb begin
      if (state_ff == tfmc_pkg::ST_ROOT) begin
         cy = -(CW'(ax_ff) <<< 8);
         cx = CW'(rge ? {root_ff[22:0], 1'b1} : {root_ff[22:0], 1'b0});
      end else begin
         cy = CW'(ay_ff) <<< 8;
         cx = CW'(az_ff) <<< 8;
      end
   end

   // square operand select: one 16x16 product per cycle
   logic signed [15:0] sqop;
   logic [31:0]        sqv;
   always_comb begin
      case (sq_ff)
         3'd0: sqop = gx_ff;
         3'd1: sqop = gy_ff;
         3'd2: sqop = gz_ff;
         3'd3: sqop = ax_ff;
         3'd4: sqop = ay_ff;
         3'd5: sqop = az_ff;
         3'd6: sqop = ps_ff;
         default: sqop = rs_ff;
      endcase
   end
   assign sqv = 32'(sqop * sqop);

   // smoothing difference and quotient by 100 (reciprocal multiply)
   logic signed [16:0] diff;
   logic [6:0]         pctc;
   logic [23:0]        pabs;
   logic [47:0]        qm;
   logic [17:0]        qabs;
   logic signed [16:0] newv;
   assign pctc = (pct_ff > 7'd100) ? 7'd100 : pct_ff;
   assign diff = (state_ff == tfmc_pkg::ST_SMOOTH_P) ? (17'(pt_ff) - 17'(ps_ff))
                                                     : (17'(rt_ff) - 17'(rs_ff));
   assign pabs = prod_ff[23] ? 24'(-prod_ff) : 24'(prod_ff);
   assign qm   = 48'(pabs) * 48'd10737419;  // ceil(2^30/100), exact over the product range
   assign qabs = qm[47:30];
   assign newv = (state_ff == tfmc_pkg::ST_SMOOTH_P ? 17'(ps_ff) : 17'(rs_ff))
               + (prod_ff[23] ? -17'(qabs) : 17'(qabs));

   // threshold squares for the inverted, tilt-minimum and upright tests
   logic [15:0] invd, tmind, upd;
   assign invd  = 16'(inv_ff) << ANGLE_FRAC_BITS;
   assign tmind = 16'(tmin_ff) << ANGLE_FRAC_BITS;
   assign upd   = 16'(up_ff) << ANGLE_FRAC_BITS;
   logic        is_inv, is_tmin, is_up;
   assign is_inv  = {1'b0, tsq_ff} >= 34'(32'(invd * invd));
   assign is_tmin = {1'b0, tsq_ff} >= 34'(32'(tmind * tmind));
   assign is_up   = {1'b0, tsq_ff} <= 34'(32'(upd * upd));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tfmc_pkg::ST_IDLE:
            if (req_valid && req_ready)
               state_in = req_kind ? tfmc_pkg::ST_TILT : tfmc_pkg::ST_SQUARE;
         tfmc_pkg::ST_SQUARE:   if (sq_ff == 3'd5) state_in = tfmc_pkg::ST_ROOT;
         tfmc_pkg::ST_ROOT:     if (cnt_ff == 5'd23) state_in = tfmc_pkg::ST_CORDIC_P;
         tfmc_pkg::ST_CORDIC_P: if (cc.done) state_in = tfmc_pkg::ST_CORDIC_R;
         tfmc_pkg::ST_CORDIC_R: if (cc.done) state_in = tfmc_pkg::ST_SMOOTH_P;
         tfmc_pkg::ST_SMOOTH_P: if (cnt_ff == 5'd8) state_in = tfmc_pkg::ST_SMOOTH_R;
         tfmc_pkg::ST_SMOOTH_R: if (cnt_ff == 5'd8) state_in = tfmc_pkg::ST_TILT;
         tfmc_pkg::ST_TILT:     if (sq_ff == 3'd7) state_in = tfmc_pkg::ST_DECIDE;
         tfmc_pkg::ST_DECIDE:   state_in = tfmc_pkg::ST_OUT;
         tfmc_pkg::ST_OUT:      if (!ov_ff || rsp_ready) state_in = tfmc_pkg::ST_IDLE;
         default:               state_in = tfmc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tfmc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         ps_ff <= '0; rs_ff <= '0; tact_ff <= 1'b0; tstart_ff <= '0;
         fall_ff <= 1'b0; mot_ff <= tfmc_pkg::MOTION_STILL; ov_ff <= 1'b0;
         cnt_ff <= '0; sq_ff <= '0;
      end else begin
         if (ov_ff && rsp_ready && state_ff != tfmc_pkg::ST_OUT) ov_ff <= 1'b0;
         case (state_ff)
            tfmc_pkg::ST_IDLE: begin
               if (req_valid && req_ready) begin
                  kind_ff <= req_kind;
                  ax_ff <= req_accel_x; ay_ff <= req_accel_y; az_ff <= req_accel_z;
                  gx_ff <= req_gyro_x; gy_ff <= req_gyro_y; gz_ff <= req_gyro_z;
                  now_ff <= req_time_ms;
                  g2_ff <= '0; a2_ff <= '0; yz2_ff <= '0;
                  sq_ff <= req_kind ? 3'd6 : 3'd0;
                  tsq_ff <= '0;
                  if (req_kind) begin
                     fall_ff <= 1'b0; tact_ff <= 1'b0;
                  end
               end
            end
            // accumulate squares, one term a cycle
            tfmc_pkg::ST_SQUARE: begin
               if (sq_ff <= 3'd2) g2_ff <= g2_ff + 34'(sqv);
               else a2_ff <= a2_ff + 34'(sqv);
               if (sq_ff >= 3'd4) yz2_ff <= yz2_ff + sqv;
               sq_ff <= sq_ff + 3'd1;
               if (sq_ff == 3'd5) begin
                  rv_ff <= {yz2_ff + sqv, 16'd0};
                  rem_ff <= '0; root_ff <= '0; cnt_ff <= '0;
               end
            end
            // one root digit a cycle
            tfmc_pkg::ST_ROOT: begin
               if (rge) begin
                  rem_ff <= rcat - {root_ff, 2'b01};
                  root_ff <= {root_ff[22:0], 1'b1};
               end else begin
                  rem_ff <= rcat;
                  root_ff <= {root_ff[22:0], 1'b0};
               end
               rv_ff <= {rv_ff[45:0], 2'b00};
               cnt_ff <= cnt_ff + 5'd1;
               // motion grade, from exact squares
               if (a2_ff > 34'(32'(alim_ff * alim_ff))) mot_ff <= tfmc_pkg::MOTION_SHOCK;
               else if (g2_ff > 34'(32'(glim_ff * glim_ff))) mot_ff <= tfmc_pkg::MOTION_MOVING;
               else mot_ff <= tfmc_pkg::MOTION_STILL;
            end
            tfmc_pkg::ST_CORDIC_P: if (cc.done) pt_ff <= cang;
            tfmc_pkg::ST_CORDIC_R: begin
               if (cc.done) begin
                  rt_ff <= cang; cnt_ff <= '0;
               end
            end
            // shift-add multiply diff*pct, then divide by 100
            tfmc_pkg::ST_SMOOTH_P, tfmc_pkg::ST_SMOOTH_R: begin
               if (cnt_ff == 5'd0) begin
                  prod_ff <= '0; mplr_ff <= pctc; cnt_ff <= 5'd1;
               end else if (cnt_ff <= 5'd7) begin
                  if (mplr_ff[6]) prod_ff <= (prod_ff <<< 1) + 24'(diff);
                  else prod_ff <= prod_ff <<< 1;
                  mplr_ff <= {mplr_ff[5:0], 1'b0};
                  cnt_ff <= cnt_ff + 5'd1;
               end else begin
                  if (state_ff == tfmc_pkg::ST_SMOOTH_P) ps_ff <= newv[15:0];
                  else begin
                     rs_ff <= newv[15:0]; sq_ff <= 3'd6; tsq_ff <= '0;
                  end
                  cnt_ff <= '0;
               end
            end
            tfmc_pkg::ST_TILT: begin
               tsq_ff <= tsq_ff + 33'(sqv);
               sq_ff <= sq_ff + 3'd1;
            end
            tfmc_pkg::ST_DECIDE: begin
               if (!kind_ff) begin
                  if (is_inv) fall_ff <= 1'b1;
                  else if (is_tmin) begin
                     if (!tact_ff) begin
                        tact_ff <= 1'b1; tstart_ff <= now_ff;
                     end else if ((now_ff - tstart_ff) >= 32'(confirm_ff))
                        fall_ff <= 1'b1;
                  end else tact_ff <= 1'b0;
               end
            end
            // post once the result register is free or being taken
            tfmc_pkg::ST_OUT: begin
               if (!ov_ff || rsp_ready) begin
                  ov_ff <= 1'b1;
                  o_p_ff <= ps_ff; o_r_ff <= rs_ff; o_mo_ff <= mot_ff;
                  o_fa_ff <= fall_ff; o_tt_ff <= tact_ff;
                  if (is_inv) o_or_ff <= tfmc_pkg::ORIENT_INVERTED;
                  else if (is_up) o_or_ff <= tfmc_pkg::ORIENT_UPRIGHT;
                  else o_or_ff <= tfmc_pkg::ORIENT_TILTED;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid        = ov_ff;
   assign rsp_pitch_angle  = o_p_ff;
   assign rsp_roll_angle   = o_r_ff;
   assign rsp_orientation  = o_or_ff;
   assign rsp_motion_level = o_mo_ff;
   assign rsp_fall_latched = o_fa_ff;
   assign rsp_tilt_timing  = o_tt_ff;

   `TFMC_ASSERT_IMPL(a_ready_idle, clock, reset, req_ready,
      state_ff == tfmc_pkg::ST_IDLE, "ready outside idle")
   `TFMC_ASSERT_NEXT(a_out_valid, clock, reset, state_ff == tfmc_pkg::ST_OUT,
      ov_ff, "result not posted")
   `TFMC_ASSERT_NEXT(a_no_overrun, clock, reset,
      state_ff == tfmc_pkg::ST_OUT && ov_ff && !rsp_ready,
      state_ff == tfmc_pkg::ST_OUT, "result register overrun")
endmodule

// File: rtl/core/tfmc_cordic.sv
// Vectoring CORDIC: atan2 in degrees, one rotation per cycle
`timescale 1ns / 1ps
`include "tilt_fall_motion_classifier_core_defines.svh"
module tfmc_cordic #(
   parameter int ANGLE_FRAC_BITS = tfmc_pkg::ANGLE_FRAC_BITS,
   parameter int CORDIC_STEPS    = tfmc_pkg::CORDIC_STEPS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [tfmc_pkg::CW-1:0] y_init,
   input  logic signed [tfmc_pkg::CW-1:0] x_init,
   output logic                          done,
   output logic signed [15:0]            angle
);
   localparam int CW = tfmc_pkg::CW;
   localparam int ZW = tfmc_pkg::ZW;
   localparam logic signed [ZW-1:0] DEG90 = 26'sd5898240;
   localparam int SH = 16 - ANGLE_FRAC_BITS;
   localparam logic signed [ZW-1:0] RND = ZW'(1) <<< (SH - 1);
   localparam logic signed [ZW-1:0] LIM = ZW'(180) <<< ANGLE_FRAC_BITS;

   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic [4:0]           i_ff, i_in;
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic signed [CW-1:0] xs, ys;
   logic signed [ZW-1:0] zr, zc;
   logic                 last;

   always_comb begin
      xs = x_ff >>> i_ff;
      ys = y_ff >>> i_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff; i_in = i_ff;
      busy_in = busy_ff; done_in = 1'b0;
      last = (i_ff == 5'(CORDIC_STEPS - 1)) || (i_ff == 5'(tfmc_pkg::ATAN_LEN - 1));
      // load with quadrant pre-rotation
      if (start) begin
         i_in = '0;
         if (x_init < 0 && y_init >= 0) begin
            x_in = y_init; y_in = -x_init; z_in = DEG90;
         end else if (x_init < 0) begin
            x_in = -y_init; y_in = x_init; z_in = -DEG90;
         end else begin
            x_in = x_init; y_in = y_init; z_in = '0;
         end
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // one rotation toward y == 0
         if (y_ff > 0) begin
            x_in = x_ff + ys; y_in = y_ff - xs;
            z_in = z_ff + $signed(tfmc_pkg::atan_q16(i_ff));
         end else if (y_ff < 0) begin
            x_in = x_ff - ys; y_in = y_ff + xs;
            z_in = z_ff - $signed(tfmc_pkg::atan_q16(i_ff));
         end
         i_in = i_ff + 5'd1;
         if (y_ff == 0 || last) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; i_ff <= i_in;
   end

   // round half up and clamp
   always_comb begin
      zr = (z_ff + RND) >>> SH;
      if (zr > LIM) zc = LIM;
      else if (zr < -LIM) zc = -LIM;
      else zc = zr;
   end
   assign done  = done_ff;
   assign angle = zc[15:0];

   `TFMC_ASSERT_NEXT(a_done_pulse, clock, reset, done_ff, !done_ff, "cordic done held")
   `TFMC_ASSERT_NEXT(a_start_busy, clock, reset, start, busy_ff, "cordic did not start")
   `TFMC_ASSERT_IMPL(a_done_idle, clock, reset, done_ff, !busy_ff, "done while busy")
endmodule
